@@ sv/gtg_pkg.sv @@
// shared constants, status codes and arctangent table for the steering controller
// no dependencies
package gtg_pkg;
	localparam int ATAN_LEN = 24;
	localparam int PI_Q20 = 3294199;
	localparam int GAIN_W = 12;
	localparam int CMD_W = 18;
	localparam int DIST_W = 17;
	localparam int ANG_W = 14;

	localparam logic [2:0] STAT_IDLE = 3'd0;
	localparam logic [2:0] STAT_DRIVE = 3'd1;
	localparam logic [2:0] STAT_ARRIVED = 3'd2;
	localparam logic [2:0] STAT_ROW_LEFT = 3'd3;
	localparam logic [2:0] STAT_OUT_BOUNDS = 3'd4;

	localparam logic [2:0] REG_LIN_GAIN = 3'd0;
	localparam logic [2:0] REG_TURN_GAIN = 3'd1;
	localparam logic [2:0] REG_TOL = 3'd2;
	localparam logic [2:0] REG_ROW_BAND = 3'd3;
	localparam logic [2:0] REG_BOUND_LOW = 3'd4;
	localparam logic [2:0] REG_BOUND_HIGH = 3'd5;

	typedef logic [20:0] atan_t;

	function automatic atan_t atan_q20(input logic [4:0] i);
		atan_t r;
		case (i)
			5'd0: r = 21'd823550;
			5'd1: r = 21'd486170;
			5'd2: r = 21'd256879;
			5'd3: r = 21'd130396;
			5'd4: r = 21'd65451;
			5'd5: r = 21'd32757;
			5'd6: r = 21'd16383;
			5'd7: r = 21'd8192;
			5'd8: r = 21'd4096;
			5'd9: r = 21'd2048;
			5'd10: r = 21'd1024;
			5'd11: r = 21'd512;
			5'd12: r = 21'd256;
			5'd13: r = 21'd128;
			5'd14: r = 21'd64;
			5'd15: r = 21'd32;
			5'd16: r = 21'd16;
			5'd17: r = 21'd8;
			5'd18: r = 21'd4;
			5'd19: r = 21'd2;
			5'd20: r = 21'd1;
			default: r = 21'd0;
		endcase
		return r;
	endfunction
endpackage

@@ sv/gtg_isqrt.sv @@
// bit-pair serial integer square root, one result bit per cycle
// depends on gtg_pkg
module gtg_isqrt (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [32:0] n,
	output logic        done,
	output logic [gtg_pkg::DIST_W-1:0] root
);
	import gtg_pkg::*;

	logic [33:0] rem_q, r_q, bit_q;
	logic [4:0]  cnt_q;
	logic        busy_q;
	logic [33:0] trial;

	assign trial = r_q + bit_q;
	assign done = !busy_q;
	assign root = r_q[DIST_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q <= 5'd0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 5'd1;
			if (cnt_q == 5'd16) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= {1'b0, n};
			r_q <= '0;
			bit_q <= 34'd1 << 32;
		end else if (busy_q) begin
			if (rem_q >= trial) begin
				rem_q <= rem_q - trial;
				r_q <= (r_q >> 1) + bit_q;
			end else begin
				r_q <= r_q >> 1;
			end
			bit_q <= bit_q >> 2;
		end
	end
endmodule

@@ sv/gtg_cordic.sv @@
// vectoring cordic for the bearing angle, one micro-rotation per cycle
// depends on gtg_pkg
module gtg_cordic #(
	parameter int STEPS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic signed [16:0] dx,
	input  logic signed [16:0] dy,
	output logic               done,
	output logic signed [gtg_pkg::ANG_W-1:0] bearing
);
	import gtg_pkg::*;

	logic signed [27:0] x_q, y_q, x0, y0;
	logic signed [23:0] z_q, zr;
	logic [4:0]         i_q;
	logic               busy_q, zero_q;
	logic signed [27:0] xs, ys;
	logic signed [23:0] at;

	assign x0 = {{3{dx[16]}}, dx, 8'd0};
	assign y0 = {{3{dy[16]}}, dy, 8'd0};
	assign xs = x_q >>> i_q;
	assign ys = y_q >>> i_q;
	assign at = {3'd0, atan_q20(i_q)};
	assign zr = z_q + 24'sd512;
	assign bearing = zero_q ? '0 : zr[23:10];
	assign done = !busy_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			i_q <= '0;
		end else if (start) begin
			busy_q <= (STEPS > 0);
			i_q <= '0;
		end else if (busy_q) begin
			i_q <= i_q + 5'd1;
			if (i_q == 5'(STEPS - 1) || i_q == 5'(ATAN_LEN - 1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			zero_q <= (dx == 0) && (dy == 0);
			if (dx < 0) begin
				x_q <= -x0;
				y_q <= -y0;
				z_q <= (dy >= 0) ? 24'(PI_Q20) : -24'(PI_Q20);
			end else begin
				x_q <= x0;
				y_q <= y0;
				z_q <= '0;
			end
		end else if (busy_q) begin
			if (y_q >= 0) begin
				x_q <= x_q + ys;
				y_q <= y_q - xs;
				z_q <= z_q + at;
			end else begin
				x_q <= x_q - ys;
				y_q <= y_q + xs;
				z_q <= z_q - at;
			end
		end
	end
endmodule

@@ sv/gtg_smul.sv @@
// shift-add gain multiplier, one gain bit per cycle, rounds and saturates
// depends on gtg_pkg
module gtg_smul (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic [gtg_pkg::GAIN_W-1:0] gain,
	input  logic signed [gtg_pkg::CMD_W-1:0] opnd,
	output logic                done,
	output logic signed [gtg_pkg::CMD_W-1:0] result
);
	import gtg_pkg::*;

	logic signed [30:0] acc_q, op_q, rnd;
	logic [GAIN_W-1:0]  g_q;
	logic [3:0]         cnt_q;
	logic               busy_q;
	logic signed [22:0] shr;

	assign done = !busy_q;
	assign rnd = acc_q + 31'sd128;
	assign shr = rnd[30:8];

	always_comb begin
		if (shr > 23'sd131071) begin
			result = 18'sd131071;
		end else if (shr < -23'sd131072) begin
			result = -18'sd131072;
		end else begin
			result = shr[CMD_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 4'd1;
			if (cnt_q == 4'(GAIN_W - 1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			acc_q <= '0;
			op_q <= 31'(opnd);
			g_q <= gain;
		end else if (busy_q) begin
			if (g_q[0]) begin
				acc_q <= acc_q + op_q;
			end
			op_q <= op_q <<< 1;
			g_q <= g_q >> 1;
		end
	end
endmodule

@@ sv/go_to_goal_steering_controller.sv @@
// go-to-goal steering controller top level: goal checks, sequencer, output register
// path of an accepted transaction when driving: goal check, root and cordic steps run in
// parallel, decision, multiply steps, finish, output load; on arrival the decision is
// followed by the output load, and otherwise the goal check goes straight to it
// one item at a time: the next item is taken the cycle after the result is loaded
// arst_n clears the sequencer, the active flag, the last goal and the registers to defaults
module go_to_goal_steering_controller #(
	parameter int CORDIC_STEPS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [79:0] s_tdata,  // pose_x, pose_y, heading, goal_x, goal_y, zero pad
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,  // speed_cmd, turn_cmd, status, zero pad
	input  logic        cfg_we,
	input  logic [2:0]  cfg_addr,
	input  logic [15:0] cfg_data
);
	import gtg_pkg::*;

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_EVAL = 3'd1;
	localparam logic [2:0] S_CALC = 3'd2;
	localparam logic [2:0] S_MUL = 3'd3;
	localparam logic [2:0] S_OUT = 3'd4;

	logic [2:0] state_q;
	logic [11:0] lin_gain_q, turn_gain_q;
	logic [14:0] tol_q, band_q;
	logic signed [15:0] blo_q, bhi_q;
	logic active_q, fresh_q;
	logic signed [15:0] last_x_q, last_y_q;
	logic signed [15:0] px_q, py_q, gx_q, gy_q;
	logic signed [12:0] hd_q;
	logic [2:0] stat_q;
	logic signed [CMD_W-1:0] spd_res_q, trn_res_q;
	logic [2:0] out_stat_q;

	logic signed [16:0] dx, dy;
	logic [32:0] dsq;
	logic in_bounds, row_left, units_start, mul_start, out_load;
	logic sq_done, co_done, sm_done, tm_done;
	logic [DIST_W-1:0] distance;
	logic signed [ANG_W-1:0] bearing;
	logic signed [CMD_W-1:0] spd, trn, err;
	logic signed [17:0] py_e, band_e;

	assign dx = 17'(gx_q) - 17'(px_q);
	assign dy = 17'(gy_q) - 17'(py_q);
	assign dsq = 33'(unsigned'(34'(dx * dx))) + 33'(unsigned'(34'(dy * dy)));
	assign in_bounds = gx_q < bhi_q && gx_q > blo_q && gy_q < bhi_q && gy_q > blo_q;
	assign py_e = 18'(py_q);
	assign band_e = 18'(signed'({1'b0, band_q}));
	assign row_left = 18'(gy_q) < py_e + band_e && 18'(gy_q) > py_e - band_e && gx_q < px_q;
	assign err = 18'(bearing) - 18'(hd_q);

	assign s_tready = (state_q == S_IDLE);
	assign units_start = (state_q == S_EVAL) &&
		(active_q || ((gx_q != last_x_q || gy_q != last_y_q) && in_bounds && !row_left));
	assign mul_start = (state_q == S_CALC) && sq_done && co_done &&
		(fresh_q || 32'(distance) > 32'(tol_q));
	assign out_load = (state_q == S_OUT) && (!m_tvalid || m_tready);

	gtg_isqrt u_sqrt (.clk, .arst_n, .start(units_start), .n(dsq), .done(sq_done), .root(distance));

	gtg_cordic #(.STEPS(CORDIC_STEPS)) u_cordic (
		.clk, .arst_n, .start(units_start), .dx, .dy, .done(co_done), .bearing
	);

	gtg_smul u_spd (
		.clk, .arst_n, .start(mul_start), .gain(lin_gain_q),
		.opnd(signed'({1'b0, distance})), .done(sm_done), .result(spd)
	);

	gtg_smul u_trn (
		.clk, .arst_n, .start(mul_start), .gain(turn_gain_q),
		.opnd(err), .done(tm_done), .result(trn)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lin_gain_q <= 12'd384;
			turn_gain_q <= 12'd2048;
			tol_q <= 15'd10;
			band_q <= 15'd512;
			blo_q <= 16'sd0;
			bhi_q <= 16'sd11264;
		end else if (cfg_we) begin
			case (cfg_addr)
				REG_LIN_GAIN: lin_gain_q <= cfg_data[11:0];
				REG_TURN_GAIN: turn_gain_q <= cfg_data[11:0];
				REG_TOL: tol_q <= cfg_data[14:0];
				REG_ROW_BAND: band_q <= cfg_data[14:0];
				REG_BOUND_LOW: blo_q <= cfg_data;
				REG_BOUND_HIGH: bhi_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			px_q <= s_tdata[15:0];
			py_q <= s_tdata[31:16];
			hd_q <= s_tdata[44:32];
			gx_q <= s_tdata[60:45];
			gy_q <= s_tdata[76:61];
		end
	end

	// sequencer, active flag, last goal and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			active_q <= 1'b0;
			fresh_q <= 1'b0;
			last_x_q <= '0;
			last_y_q <= '0;
			stat_q <= STAT_IDLE;
			m_tvalid <= 1'b0;
			spd_res_q <= '0;
			trn_res_q <= '0;
			out_stat_q <= STAT_IDLE;
		end else begin
			if (out_load) begin
				m_tvalid <= 1'b1;
			end else if (m_tvalid && m_tready) begin
				m_tvalid <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (s_tvalid) begin
						state_q <= S_EVAL;
					end
				end
				S_EVAL: begin
					// acceptance tick drives without the arrival test
					fresh_q <= units_start && !active_q;
					if (active_q) begin
						state_q <= S_CALC;
					end else if (gx_q != last_x_q || gy_q != last_y_q) begin
						last_x_q <= gx_q;
						last_y_q <= gy_q;
						if (!in_bounds) begin
							stat_q <= STAT_OUT_BOUNDS;
							state_q <= S_OUT;
						end else if (row_left) begin
							stat_q <= STAT_ROW_LEFT;
							state_q <= S_OUT;
						end else begin
							active_q <= 1'b1;
							state_q <= S_CALC;
						end
					end else begin
						stat_q <= STAT_IDLE;
						state_q <= S_OUT;
					end
				end
				S_CALC: begin
					if (sq_done && co_done) begin
						if (mul_start) begin
							stat_q <= STAT_DRIVE;
							state_q <= S_MUL;
						end else begin
							active_q <= 1'b0;
							last_x_q <= gx_q;
							last_y_q <= gy_q;
							stat_q <= STAT_ARRIVED;
							state_q <= S_OUT;
						end
					end
				end
				S_MUL: begin
					if (sm_done && tm_done) begin
						state_q <= S_OUT;
					end
				end
				S_OUT: begin
					if (out_load) begin
						out_stat_q <= stat_q;
						spd_res_q <= (stat_q == STAT_DRIVE) ? spd : '0;
						trn_res_q <= (stat_q == STAT_DRIVE) ? trn : '0;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign m_tdata = {1'b0, out_stat_q, trn_res_q, spd_res_q};
endmodule

@@ tb/sv/tb_go_to_goal_steering_controller.sv @@
// testbench for the go-to-goal steering controller: random and directed control ticks
// checked against a behavioural predictor; depends on gtg_pkg and the top level
`timescale 1ns / 100ps

module tb_go_to_goal_steering_controller;
	import gtg_pkg::*;

	typedef struct packed {
		logic signed [15:0] goal_y;
		logic signed [15:0] goal_x;
		logic signed [12:0] heading;
		logic signed [15:0] pose_y;
		logic signed [15:0] pose_x;
	} tick_t;

	typedef struct packed {
		logic [2:0]         status;
		logic signed [17:0] turn_cmd;
		logic signed [17:0] speed_cmd;
	} cmd_t;

	localparam longint MAX_CYCLES = 2000000;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [79:0] s_tdata;
	logic        m_tvalid;
	logic        m_tready;
	logic [39:0] m_tdata;
	logic        cfg_we;
	logic [2:0]  cfg_addr;
	logic [15:0] cfg_data;

	go_to_goal_steering_controller u_top (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_data(cfg_data)
	);

	// predictor state and registers
	longint lin_gain, trn_gain, tol, band, blo, bhi;
	bit     driving;
	longint prev_gx, prev_gy;

	tick_t  tick_q[$];
	cmd_t   cmd_q[$];
	int     send_idle_pct, recv_idle_pct;
	int     errors;
	longint cycles;
	bit     cfg_pending;
	logic [2:0]  cfg_idx_n;
	logic [15:0] cfg_val_n;

	function automatic longint shr(longint v, int s);
		return v >>> s;
	endfunction

	function automatic longint int_sqrt(longint n);
		longint r, b;
		r = 0;
		b = 64'sd1 << 62;
		while (b > n) b = b >> 2;
		while (b != 0) begin
			if (n >= r + b) begin
				n = n - (r + b);
				r = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
			b = b >> 2;
		end
		return r;
	endfunction

	function automatic longint bearing(longint dx, longint dy);
		longint x, y, z, xs, ys;
		x = dx * 256;
		y = dy * 256;
		z = 0;
		if (dx == 0 && dy == 0) return 0;
		if (dx < 0) begin
			z = (dy >= 0) ? PI_Q20 : -PI_Q20;
			x = -x;
			y = -y;
		end
		for (int i = 0; i < 16; i++) begin
			xs = shr(x, i);
			ys = shr(y, i);
			if (y >= 0) begin
				x += ys; y -= xs; z += longint'(atan_q20(i[4:0]));
			end else begin
				x -= ys; y += xs; z -= longint'(atan_q20(i[4:0]));
			end
		end
		return shr(z + 512, 10);
	endfunction

	function automatic longint sat18(longint v);
		if (v > 131071) return 131071;
		if (v < -131072) return -131072;
		return v;
	endfunction

	function automatic cmd_t steer(tick_t t);
		cmd_t   c;
		longint px, py, hd, gx, gy, dx, dy, d;
		bit     go;
		px = t.pose_x; py = t.pose_y; hd = t.heading; gx = t.goal_x; gy = t.goal_y;
		c = '0;
		c.status = STAT_IDLE;
		go = 0;
		dx = gx - px;
		dy = gy - py;
		d = int_sqrt(dx * dx + dy * dy);
		if (!driving) begin
			if (gx != prev_gx || gy != prev_gy) begin
				prev_gx = gx;
				prev_gy = gy;
				if (!(gx < bhi && gx > blo && gy < bhi && gy > blo))
					c.status = STAT_OUT_BOUNDS;
				else if (gy < py + band && gy > py - band && gx < px)
					c.status = STAT_ROW_LEFT;
				else begin
					driving = 1;
					go = 1;
				end
			end
		end else if (d <= tol) begin
			driving = 0;
			prev_gx = gx;
			prev_gy = gy;
			c.status = STAT_ARRIVED;
		end else begin
			go = 1;
		end
		if (go) begin
			c.speed_cmd = 18'(sat18(shr(lin_gain * d + 128, 8)));
			c.turn_cmd = 18'(sat18(shr(trn_gain * (bearing(dx, dy) - hd) + 128, 8)));
			c.status = STAT_DRIVE;
		end
		return c;
	endfunction

	function automatic tick_t rand_tick();
		tick_t t;
		t.pose_x = 16'($urandom);
		t.pose_y = 16'($urandom);
		t.heading = 13'($signed($urandom_range(6434)) - 3217);
		t.goal_x = 16'($urandom);
		t.goal_y = 16'($urandom);
		return t;
	endfunction

	// a goal run: new goal inside the workspace, then a pose walking towards it
	task automatic add_run();
		tick_t  t;
		longint gx, gy, px, py, lo, hi;
		int     steps;
		lo = blo + 1;
		hi = bhi - 1;
		if (hi < lo) begin
			hi = lo;
		end
		gx = lo + $urandom_range(int'(hi - lo));
		gy = lo + $urandom_range(int'(hi - lo));
		px = gx + $signed($urandom_range(8000)) - 4000;
		py = gy + $signed($urandom_range(8000)) - 4000;
		steps = $urandom_range(6, 1);
		for (int s = 0; s <= steps + 1; s++) begin
			t.goal_x = 16'(gx);
			t.goal_y = 16'(gy);
			t.heading = 13'($signed($urandom_range(6434)) - 3217);
			if (s >= steps) begin
				px = gx + $signed($urandom_range(6)) - 3;
				py = gy + $signed($urandom_range(6)) - 3;
			end else begin
				px = px + (gx - px) / 2;
				py = py + (gy - py) / 2;
			end
			t.pose_x = 16'(px);
			t.pose_y = 16'(py);
			tick_q.push_back(t);
		end
	endtask

	task automatic add(input longint px, py, hd, gx, gy);
		tick_t t;
		t.pose_x = 16'(px); t.pose_y = 16'(py); t.heading = 13'(hd);
		t.goal_x = 16'(gx); t.goal_y = 16'(gy);
		tick_q.push_back(t);
	endtask

	// sampled on the falling edge so the driver's updates have settled
	task automatic wait_drained();
		while (tick_q.size() != 0 || cmd_q.size() != 0 || s_tvalid) @(negedge clk);
		repeat (40) @(posedge clk);
	endtask

	task automatic write_reg(input logic [2:0] idx, input longint val);
		cfg_idx_n = idx;
		cfg_val_n = 16'(val);
		cfg_pending = 1;
		@(posedge clk);
		while (cfg_pending) @(posedge clk);
		case (idx)
			REG_LIN_GAIN: lin_gain = val & 12'hfff;
			REG_TURN_GAIN: trn_gain = val & 12'hfff;
			REG_TOL: tol = val & 15'h7fff;
			REG_ROW_BAND: band = val & 15'h7fff;
			REG_BOUND_LOW: blo = longint'($signed(16'(val)));
			default: bhi = longint'($signed(16'(val)));
		endcase
	endtask

	initial begin
		clk = 0;
		forever #4 clk = ~clk;
	end

	// config writes
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_we <= 0;
			cfg_addr <= '0;
			cfg_data <= '0;
		end else if (cfg_pending && !cfg_we) begin
			cfg_we <= 1;
			cfg_addr <= cfg_idx_n;
			cfg_data <= cfg_val_n;
		end else if (cfg_we) begin
			cfg_we <= 0;
			cfg_pending <= 0;
		end
	end

	// tick driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 0;
			s_tdata <= '0;
		end else if (!s_tvalid || s_tready) begin
			if (s_tvalid) cmd_q.push_back(steer(tick_t'(s_tdata[76:0])));
			if (tick_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
				s_tvalid <= 1;
				s_tdata <= {3'b0, tick_q.pop_front()};
			end else begin
				s_tvalid <= 0;
			end
		end
	end

	// result monitor
	always @(posedge clk or negedge arst_n) begin
		cmd_t got, want;
		if (!arst_n) begin
			m_tready <= 0;
		end else begin
			if (m_tvalid && m_tready) begin
				got = cmd_t'(m_tdata[38:0]);
				if (cmd_q.size() == 0) begin
					$error("command with nothing expected: %h", m_tdata);
					errors++;
				end else begin
					want = cmd_q.pop_front();
					if (got.speed_cmd !== want.speed_cmd) begin
						$error("speed_cmd exp %0d got %0d", want.speed_cmd, got.speed_cmd);
						errors++;
					end
					if (got.turn_cmd !== want.turn_cmd) begin
						$error("turn_cmd exp %0d got %0d", want.turn_cmd, got.turn_cmd);
						errors++;
					end
					if (got.status !== want.status) begin
						$error("status exp %0d got %0d", want.status, got.status);
						errors++;
					end
				end
			end
			m_tready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > MAX_CYCLES) begin
			$display("FAIL");
			$finish;
		end
	end

	initial begin
		errors = 0;
		cycles = 0;
		cfg_pending = 0;
		send_idle_pct = 26;
		recv_idle_pct = 67;
		lin_gain = 384; trn_gain = 2048; tol = 10; band = 512; blo = 0; bhi = 11264;
		driving = 0; prev_gx = 0; prev_gy = 0;
		arst_n = 0;
		repeat (6) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed: idle same goal, out of bounds, row left, zero vector, extremes
		add(0, 0, 0, 0, 0);
		add(0, 0, 0, -32768, 5000);
		add(0, 0, 0, 5000, 32767);
		add(0, 0, 0, 11264, 5000);
		add(6000, 5000, 0, 3000, 5100);
		add(3000, 5000, -3217, 5000, 5000);
		add(5000, 5000, 3217, 5000, 5000);
		add(-32768, -32768, 3217, 2000, 2000);
		add(32767, 32767, -3217, 2000, 2000);
		add(1000, 3000, 0, 2000, 2000);
		add(1000, 1000, 0, 2000, 2001);
		add(2000, 2001, 0, 2000, 2001);
		add(6000, 6000, -3217, 100, 200);
		add(6000, 6000, 0, 9000, 200);
		add(100, 200, 0, 9000, 200);
		add(9000, 205, 0, 9000, 200);
		wait_drained();

		write_reg(REG_LIN_GAIN, 4095);
		write_reg(REG_TURN_GAIN, 4095);
		write_reg(REG_TOL, 0);
		write_reg(REG_ROW_BAND, 32767);
		write_reg(REG_BOUND_LOW, -32768);
		write_reg(REG_BOUND_HIGH, 32767);
		add(-32768, -32768, -3217, 32766, 32766);
		add(32767, -32768, 3217, -32767, 32766);
		add(-32767, 32766, 0, -32767, 32766);
		add(0, 0, 0, 5, 5);
		repeat (60) begin
			if ($urandom_range(3) == 0) tick_q.push_back(rand_tick());
			else add_run();
		end
		wait_drained();

		write_reg(REG_LIN_GAIN, 0);
		write_reg(REG_TURN_GAIN, 0);
		write_reg(REG_TOL, 32767);
		write_reg(REG_ROW_BAND, 0);
		write_reg(REG_BOUND_LOW, 5000);
		write_reg(REG_BOUND_HIGH, 4000);
		repeat (40) tick_q.push_back(rand_tick());
		wait_drained();

		for (int ph = 0; ph < 3; ph++) begin
			send_idle_pct = (ph == 0) ? 26 : (ph == 1) ? 67 : 0;
			recv_idle_pct = (ph == 0) ? 67 : (ph == 1) ? 26 : 0;
			write_reg(REG_LIN_GAIN, $urandom_range(4095));
			write_reg(REG_TURN_GAIN, $urandom_range(4095));
			write_reg(REG_TOL, $urandom_range(200));
			write_reg(REG_ROW_BAND, $urandom_range(2000));
			write_reg(REG_BOUND_LOW, $signed($urandom_range(4000)) - 2000);
			write_reg(REG_BOUND_HIGH, 8000 + $urandom_range(20000));
			while (tick_q.size() < 175) begin
				if ($urandom_range(4) == 0) tick_q.push_back(rand_tick());
				else add_run();
			end
			wait_drained();
		end

		if (errors == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end
endmodule
